/* rtl/qtve_pkg.sv */
// ----------------------------------------------------------------------------
// qtve_pkg
// Shared types and constants for the query token value extractor.
// ----------------------------------------------------------------------------
package qtve_pkg;

  localparam int unsigned NAME_CHARS = 16;
  localparam int unsigned NAME_IDX_W = $clog2(NAME_CHARS);
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUEST = 8'h3F;

  typedef enum logic [2:0] {
    PH_SEARCH  = 3'b001,
    PH_CAPTURE = 3'b010,
    PH_DONE    = 3'b100
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NAME_LOW  = 2'd0,
    CFG_NAME_HIGH = 2'd1,
    CFG_NAME_LEN  = 2'd2
  } cfg_idx_e;

  typedef logic [NAME_CHARS-1:0][7:0] name_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } win_ctrl_t;

  typedef struct packed {
    logic amp_wr;
    logic q_wr;
    logic load;
    logic load_q;
    logic drain_shift;
  } val_ctrl_t;

endpackage

/* rtl/qtve_intf.sv */
// ----------------------------------------------------------------------------
// qtve interfaces
// Text input, value output and configuration write channels.
// ----------------------------------------------------------------------------
interface qtve_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface qtve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       byte_valid;
  logic       found;
  logic       via_question;
  logic       last;

  modport source (output valid, output value_byte, output byte_valid, output found,
                  output via_question, output last, input ready);
  modport sink   (input valid, input value_byte, input byte_valid, input found,
                  input via_question, input last, output ready);
endinterface

interface qtve_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/qtve_win_cell.sv */
// ----------------------------------------------------------------------------
// qtve_win_cell
// One position of the recent-byte window with its pattern compare.
// ----------------------------------------------------------------------------
module qtve_win_cell
  import qtve_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  win_ctrl_t        ctrl_i,
  input  logic [7:0]       byte_i,
  input  name_t            name_i,
  input  logic [LEN_W-1:0] len_i,
  output logic [7:0]       byte_o,
  output logic             amp_ok_o,
  output logic             q_ok_o
);

  localparam logic [LEN_W-1:0] Pos = LEN_W'(IDX);

  logic [7:0]            byte_q;
  logic [LEN_W-1:0]      off;
  logic [NAME_IDX_W-1:0] sel;
  logic                  name_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else if (ctrl_i.clr) begin
      byte_q <= 8'h00;
    end else if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign off      = len_i - Pos - LEN_W'(1);
  assign sel      = off[NAME_IDX_W-1:0];
  assign name_hit = (byte_q == name_i[sel]);

  always_comb begin
    if (Pos < len_i) begin
      amp_ok_o = name_hit;
      q_ok_o   = name_hit;
    end else if (Pos == len_i) begin
      amp_ok_o = (byte_q == CH_AMP);
      q_ok_o   = (byte_q == CH_QUEST);
    end else begin
      amp_ok_o = 1'b1;
      q_ok_o   = 1'b1;
    end
  end

  assign byte_o = byte_q;

endmodule

/* rtl/qtve_val_cell.sv */
// ----------------------------------------------------------------------------
// qtve_val_cell
// One value position: both capture bytes and the output drain byte.
// ----------------------------------------------------------------------------
module qtve_val_cell
  import qtve_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic          clk_i,
  input  val_ctrl_t     ctrl_i,
  input  logic [CW-1:0] amp_cnt_i,
  input  logic [CW-1:0] q_cnt_i,
  input  logic [7:0]    byte_i,
  input  logic [7:0]    drain_i,
  output logic [7:0]    drain_o
);

  logic [7:0] amp_q;
  logic [7:0] q_q;
  logic [7:0] drain_q;
  logic       amp_we;
  logic       q_we;
  logic [7:0] src;

  assign amp_we = ctrl_i.amp_wr && (amp_cnt_i == CW'(IDX));
  assign q_we   = ctrl_i.q_wr && (q_cnt_i == CW'(IDX));

  always_comb begin
    if (ctrl_i.load_q) begin
      src = q_we ? byte_i : q_q;
    end else begin
      src = amp_we ? byte_i : amp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (amp_we) begin
      amp_q <= byte_i;
    end
    if (q_we) begin
      q_q <= byte_i;
    end
    if (ctrl_i.load) begin
      drain_q <= src;
    end else if (ctrl_i.drain_shift) begin
      drain_q <= drain_i;
    end
  end

  assign drain_o = drain_q;

endmodule

/* rtl/query_token_value_extractor.sv */
// ----------------------------------------------------------------------------
// query_token_value_extractor
// Finds &name= / ?name= in a byte stream and returns the value that follows.
// ----------------------------------------------------------------------------
// Usage:
//   text_i  : one text byte per transfer, end_of_text on the final byte.
//   value_o : value bytes, one per transfer, last set on the final one; a
//             lone transfer with byte_valid low when nothing was captured.
//   cfg_i   : register writes (name bytes, name length), always ready; write
//             only while no run is pending.
// Throughput is one text byte per cycle: the window compare and capture
// update of a byte complete in the cycle it is transferred. A byte that ends
// the text (NUL or end_of_text) copies the captured value into the drain
// chain; the run starts on value_o the next cycle and moves one byte per
// cycle. Text keeps flowing while a run drains; only a further ending byte
// waits (ready low) until the last byte of the previous run is taken, so a
// stalled receiver holds back text at the next text end only.
// Reset clears the window, the capture phases and counts and any pending
// run; name registers return to zero with length one.
// ----------------------------------------------------------------------------
module query_token_value_extractor
  import qtve_pkg::*;
#(
  parameter int unsigned MAX_NAME  = 16,
  parameter int unsigned MAX_VALUE = 30
) (
  input  logic clk_i,
  input  logic rst_ni,
  qtve_in_if.sink    text_i,
  qtve_out_if.source value_o,
  qtve_cfg_if.sink   cfg_i
);

  localparam int unsigned WinDepth = MAX_NAME + 1;
  localparam int unsigned CW       = $clog2(MAX_VALUE + 1);

  logic [63:0]      name_lo_q;
  logic [63:0]      name_hi_q;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] len_eff;
  name_t            name;

  logic             closed_q, closed_d;
  phase_e           amp_ph_q, amp_ph_d, amp_ph_u;
  phase_e           q_ph_q, q_ph_d, q_ph_u;
  logic [CW-1:0]    amp_cnt_q, amp_cnt_d, amp_cnt_u;
  logic [CW-1:0]    q_cnt_q, q_cnt_d, q_cnt_u;

  logic             busy_q;
  logic [CW-1:0]    rem_q;
  logic             found_q, viaq_q, empty_q;

  logic [7:0]       c;
  logic             eot, in_fire, out_fire, cfg_fire;
  logic             live, is_nul, term, would_emit, step, emit_go;
  logic             amp_cap, q_cap, amp_match, q_match;
  logic             amp_found, q_found, via_q, last;
  logic [CW-1:0]    sel_cnt;

  win_ctrl_t        win_ctrl;
  val_ctrl_t        val_ctrl;

  logic [WinDepth-1:0][7:0] win_byte;
  logic [WinDepth-1:0]      amp_ok, q_ok;
  logic [MAX_VALUE-1:0][7:0] drain;

  // configuration
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_lo_q <= '0;
      name_hi_q <= '0;
      len_q     <= LEN_W'(1);
    end else if (cfg_fire) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_NAME_LOW:  name_lo_q <= cfg_i.data;
        CFG_NAME_HIGH: name_hi_q <= cfg_i.data;
        CFG_NAME_LEN:  len_q     <= cfg_i.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign name    = {name_hi_q, name_lo_q};
  assign len_eff = (len_q > LEN_W'(MAX_NAME)) ? LEN_W'(MAX_NAME) : len_q;

  // input side
  assign c          = text_i.text_byte;
  assign eot        = text_i.end_of_text;
  assign live       = !closed_q;
  assign is_nul     = (c == CH_NUL);
  assign would_emit = live && (is_nul || eot);
  assign text_i.ready = !would_emit || !busy_q || (out_fire && last);
  assign in_fire    = text_i.valid && text_i.ready;
  assign step       = in_fire && live && !is_nul;
  assign emit_go    = in_fire && would_emit;

  always_comb begin
    term = 1'b0;
    if (c inside {CH_AMP, CH_SEMI, CH_LF}) begin
      term = 1'b1;
    end
  end

  // window chain
  assign win_ctrl.shift = step;
  assign win_ctrl.clr   = in_fire && eot;

  for (genvar i = 0; i < WinDepth; i++) begin : g_win
    logic [7:0] b_in;
    if (i == 0) begin : g_head
      assign b_in = c;
    end else begin : g_link
      assign b_in = win_byte[i-1];
    end
    qtve_win_cell #(.IDX(i)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (win_ctrl),
      .byte_i   (b_in),
      .name_i   (name),
      .len_i    (len_eff),
      .byte_o   (win_byte[i]),
      .amp_ok_o (amp_ok[i]),
      .q_ok_o   (q_ok[i])
    );
  end

  assign amp_match = (c == CH_EQ) && (&amp_ok);
  assign q_match   = (c == CH_EQ) && (&q_ok);

  // capture control
  assign amp_cap = step && (amp_ph_q == PH_CAPTURE);
  assign q_cap   = step && (q_ph_q == PH_CAPTURE);

  always_comb begin
    amp_ph_u  = amp_ph_q;
    amp_cnt_u = amp_cnt_q;
    if (amp_cap) begin
      if (term) begin
        amp_ph_u = PH_DONE;
      end else begin
        amp_cnt_u = amp_cnt_q + CW'(1);
        if (amp_cnt_u == CW'(MAX_VALUE)) begin
          amp_ph_u = PH_DONE;
        end
      end
    end
    if (step && (amp_ph_q == PH_SEARCH) && amp_match) begin
      amp_ph_u = PH_CAPTURE;
    end
  end

  always_comb begin
    q_ph_u  = q_ph_q;
    q_cnt_u = q_cnt_q;
    if (q_cap) begin
      if (term) begin
        q_ph_u = PH_DONE;
      end else begin
        q_cnt_u = q_cnt_q + CW'(1);
        if (q_cnt_u == CW'(MAX_VALUE)) begin
          q_ph_u = PH_DONE;
        end
      end
    end
    if (step && (q_ph_q == PH_SEARCH) && q_match) begin
      q_ph_u = PH_CAPTURE;
    end
  end

  always_comb begin
    closed_d  = closed_q;
    amp_ph_d  = amp_ph_q;
    q_ph_d    = q_ph_q;
    amp_cnt_d = amp_cnt_q;
    q_cnt_d   = q_cnt_q;
    if (in_fire) begin
      if (eot) begin
        closed_d  = 1'b0;
        amp_ph_d  = PH_SEARCH;
        q_ph_d    = PH_SEARCH;
        amp_cnt_d = '0;
        q_cnt_d   = '0;
      end else begin
        closed_d  = closed_q || is_nul;
        amp_ph_d  = amp_ph_u;
        q_ph_d    = q_ph_u;
        amp_cnt_d = amp_cnt_u;
        q_cnt_d   = q_cnt_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q  <= 1'b0;
      amp_ph_q  <= PH_SEARCH;
      q_ph_q    <= PH_SEARCH;
      amp_cnt_q <= '0;
      q_cnt_q   <= '0;
    end else begin
      closed_q  <= closed_d;
      amp_ph_q  <= amp_ph_d;
      q_ph_q    <= q_ph_d;
      amp_cnt_q <= amp_cnt_d;
      q_cnt_q   <= q_cnt_d;
    end
  end

  // run selection
  assign amp_found = (amp_ph_u != PH_SEARCH);
  assign q_found   = (q_ph_u != PH_SEARCH);
  assign via_q     = !amp_found && q_found;

  always_comb begin
    if (amp_found) begin
      sel_cnt = amp_cnt_u;
    end else if (q_found) begin
      sel_cnt = q_cnt_u;
    end else begin
      sel_cnt = '0;
    end
  end

  // value chain
  assign last     = empty_q || (rem_q == CW'(1));
  assign out_fire = value_o.valid && value_o.ready;

  assign val_ctrl.amp_wr      = amp_cap && !term;
  assign val_ctrl.q_wr        = q_cap && !term;
  assign val_ctrl.load        = emit_go;
  assign val_ctrl.load_q      = via_q;
  assign val_ctrl.drain_shift = out_fire && !last;

  for (genvar k = 0; k < MAX_VALUE; k++) begin : g_val
    logic [7:0] d_in;
    if (k == MAX_VALUE - 1) begin : g_tail
      assign d_in = 8'h00;
    end else begin : g_link
      assign d_in = drain[k+1];
    end
    qtve_val_cell #(.IDX(k), .CW(CW)) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (val_ctrl),
      .amp_cnt_i (amp_cnt_q),
      .q_cnt_i   (q_cnt_q),
      .byte_i    (c),
      .drain_i   (d_in),
      .drain_o   (drain[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      rem_q   <= '0;
      found_q <= 1'b0;
      viaq_q  <= 1'b0;
      empty_q <= 1'b0;
    end else if (emit_go) begin
      busy_q  <= 1'b1;
      rem_q   <= sel_cnt;
      found_q <= amp_found || q_found;
      viaq_q  <= via_q;
      empty_q <= (sel_cnt == '0);
    end else if (out_fire) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        rem_q <= rem_q - CW'(1);
      end
    end
  end

  assign value_o.valid        = busy_q;
  assign value_o.value_byte   = empty_q ? 8'h00 : drain[0];
  assign value_o.byte_valid   = !empty_q;
  assign value_o.found        = found_q;
  assign value_o.via_question = viaq_q;
  assign value_o.last         = last;

endmodule

/* rtl/qtve_checker.sv */
// ----------------------------------------------------------------------------
// qtve_checker
// Port-level checks on the value output of the extractor.
// ----------------------------------------------------------------------------
module qtve_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] value_byte_i,
  input logic       byte_valid_i,
  input logic       found_i,
  input logic       via_question_i,
  input logic       last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(value_byte_i) && $stable(last_i))
    else $error("value output changed while stalled");

  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=>
      out_valid_i && found_i && byte_valid_i && (via_question_i == $past(via_question_i)))
    else $error("run broken before its last transfer");

  a_none_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> !byte_valid_i && last_i && !via_question_i)
    else $error("byte returned without a match");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> last_i && (value_byte_i == 8'h00))
    else $error("empty result not a lone last transfer");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid straight after reset");

endmodule

bind query_token_value_extractor qtve_checker u_qtve_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (value_o.valid),
  .out_ready_i    (value_o.ready),
  .value_byte_i   (value_o.value_byte),
  .byte_valid_i   (value_o.byte_valid),
  .found_i        (value_o.found),
  .via_question_i (value_o.via_question),
  .last_i         (value_o.last)
);

/* sim/qtve_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtve_tb_pkg
// Value predictor and result scoreboard for the query token value extractor.
// Tracks the name registers, the byte window and both captures, queues the
// value run each text end produces and checks received transfers against it.
// ----------------------------------------------------------------------------
package qtve_tb_pkg;

  import qtve_pkg::*;

  localparam int unsigned VALUE_MAX    = 30;
  localparam int unsigned WINDOW_DEPTH = 17;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       found;
    logic       via_question;
    logic       last;
  } value_beat_t;

  class query_value_board;
    logic [63:0] name_lo;
    logic [63:0] name_hi;
    logic [4:0]  name_len;
    logic [7:0]  window [WINDOW_DEPTH];
    logic [7:0]  vbuf [2][VALUE_MAX];
    int unsigned cnt [2];
    phase_e      ph [2];
    bit          closed;
    value_beat_t expected_run [$];
    int unsigned mismatches;

    function new();
      name_lo    = '0;
      name_hi    = '0;
      name_len   = 5'd1;
      mismatches = 0;
      rearm();
    endfunction

    function void rearm();
      foreach (window[k]) window[k] = 8'h00;
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < VALUE_MAX; k++) vbuf[s][k] = 8'h00;
        cnt[s] = 0;
        ph[s]  = PH_SEARCH;
      end
      closed = 1'b0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [63:0] d);
      case (idx)
        CFG_NAME_LOW:  name_lo  = d;
        CFG_NAME_HIGH: name_hi  = d;
        CFG_NAME_LEN:  name_len = d[4:0];
        default: ;
      endcase
    endfunction

    function int unsigned name_chars();
      return (name_len > NAME_CHARS) ? NAME_CHARS : int'(name_len);
    endfunction

    function logic [7:0] name_byte(int unsigned j);
      if (j < 8) return name_lo[8*j +: 8];
      return name_hi[8*(j-8) +: 8];
    endfunction

    // byte k of lead, name, '='
    function logic [7:0] pattern_byte(logic [7:0] lead, int unsigned k, int unsigned n);
      if (k == 0) return lead;
      if (k <= n) return name_byte(k - 1);
      return CH_EQ;
    endfunction

    function bit window_hit(logic [7:0] lead, logic [7:0] c);
      int unsigned n;
      int unsigned plen;
      n    = name_chars();
      plen = n + 2;
      if (c != CH_EQ) return 1'b0;
      for (int unsigned k = 1; k < plen; k++)
        if (window[k-1] != pattern_byte(lead, plen - 1 - k, n)) return 1'b0;
      return 1'b1;
    endfunction

    function void queue_run();
      bit          amp_f;
      bit          q_f;
      bit          via_q;
      int unsigned src;
      int unsigned n;
      value_beat_t beat;
      amp_f = ph[0] != PH_SEARCH;
      q_f   = ph[1] != PH_SEARCH;
      via_q = !amp_f && q_f;
      src   = via_q ? 1 : 0;
      n     = (amp_f || q_f) ? cnt[src] : 0;
      if (n == 0) begin
        beat.value_byte   = 8'h00;
        beat.byte_valid   = 1'b0;
        beat.found        = amp_f || q_f;
        beat.via_question = via_q;
        beat.last         = 1'b1;
        expected_run.push_back(beat);
      end else begin
        for (int unsigned k = 0; k < n; k++) begin
          beat.value_byte   = vbuf[src][k];
          beat.byte_valid   = 1'b1;
          beat.found        = 1'b1;
          beat.via_question = via_q;
          beat.last         = (k + 1 == n);
          expected_run.push_back(beat);
        end
      end
    endfunction

    function void take_text(logic [7:0] c, logic eot);
      bit amp_hit;
      bit q_hit;
      if (!closed) begin
        if (c == CH_NUL) begin
          closed = 1'b1;
          queue_run();
        end else begin
          for (int s = 0; s < 2; s++) begin
            if (ph[s] == PH_CAPTURE) begin
              if (c == CH_AMP || c == CH_SEMI || c == CH_LF) begin
                ph[s] = PH_DONE;
              end else begin
                if (cnt[s] < VALUE_MAX) begin
                  vbuf[s][cnt[s]] = c;
                  cnt[s]++;
                end
                if (cnt[s] >= VALUE_MAX) ph[s] = PH_DONE;
              end
            end
          end
          amp_hit = (ph[0] == PH_SEARCH) && window_hit(CH_AMP, c);
          q_hit   = (ph[1] == PH_SEARCH) && window_hit(CH_QUEST, c);
          if (amp_hit) ph[0] = PH_CAPTURE;
          if (q_hit) ph[1] = PH_CAPTURE;
          for (int k = WINDOW_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
          window[0] = c;
          if (eot) queue_run();
        end
      end
      if (eot) rearm();
    endfunction

    function void check_value(value_beat_t got);
      value_beat_t want;
      if (expected_run.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected value transfer: byte %02h valid %0b found %0b via_q %0b last %0b",
                   got.value_byte, got.byte_valid, got.found, got.via_question, got.last);
        return;
      end
      want = expected_run.pop_front();
      if (got.value_byte !== want.value_byte || got.byte_valid !== want.byte_valid ||
          got.found !== want.found || got.via_question !== want.via_question ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("value mismatch: exp byte %02h valid %0b found %0b via_q %0b last %0b, %s",
                   want.value_byte, want.byte_valid, want.found, want.via_question, want.last,
                   $sformatf("got byte %02h valid %0b found %0b via_q %0b last %0b",
                             got.value_byte, got.byte_valid, got.found, got.via_question,
                             got.last));
      end
    endfunction

    function int unsigned pending();
      return expected_run.size();
    endfunction
  endclass

endpackage

/* sim/query_token_value_extractor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_token_value_extractor_tb
// Feeds query-like texts byte by byte, with directed corner cases first and
// then random well-formed and broken name patterns under several name
// settings and idle/stall mixes; every value transfer is checked in order.
// ----------------------------------------------------------------------------
module query_token_value_extractor_tb;

  import qtve_pkg::*;
  import qtve_tb_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 62;
  localparam int unsigned SETTLE_CYC  = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  qtve_in_if  txt_if ();
  qtve_out_if val_if ();
  qtve_cfg_if cfg_if ();

  query_token_value_extractor DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (txt_if),
    .value_o (val_if),
    .cfg_i   (cfg_if)
  );

  query_value_board sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned quiet_cycles   = 0;
  logic [7:0]  text_q [$];

  always #6 clk_i = ~clk_i;

  // value receiver
  always @(posedge clk_i) begin
    if (rst_ni && val_if.valid && val_if.ready)
      sb.check_value({val_if.value_byte, val_if.byte_valid, val_if.found,
                      val_if.via_question, val_if.last});
    val_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((txt_if.valid && txt_if.ready) || (val_if.valid && val_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      txt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    txt_if.valid       <= 1'b1;
    txt_if.text_byte   <= b;
    txt_if.end_of_text <= eot;
    @(posedge clk_i);
    while (!txt_if.ready) @(posedge clk_i);
    sb.take_text(b, eot);
    items_sent++;
  endtask

  task automatic send_str(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close && (i == s.len() - 1));
  endtask

  task automatic wait_results();
    txt_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic settle();
    wait_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, d);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_name(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] len);
    settle();
    write_reg(CFG_NAME_LOW, lo);
    write_reg(CFG_NAME_HIGH, hi);
    write_reg(CFG_NAME_LEN, {59'd0, len});
  endtask

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    for (int k = 0; k < 8; k++) w[8*k +: 8] = 8'($urandom_range(97, 122));
    return w;
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    if ($urandom_range(99) < 15) return 8'($urandom_range(1, 255));
    c = 8'($urandom_range(33, 126));
    if (c == CH_AMP || c == CH_SEMI) c = 8'h76;
    return c;
  endfunction

  task automatic build_text();
    int unsigned n;
    int unsigned m;
    int unsigned vlen;
    int unsigned r;
    text_q.delete();
    n = sb.name_chars();
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(99);
      if (r < 75) begin
        text_q.push_back((r < 40) ? CH_AMP : CH_QUEST);
        m = (r < 65) ? n : $urandom_range(0, n);
        for (int unsigned j = 0; j < m; j++) text_q.push_back(sb.name_byte(j));
        if (r < 70) text_q.push_back(CH_EQ);
        vlen = ($urandom_range(9) == 0) ? $urandom_range(26, 36) : $urandom_range(0, 6);
        repeat (vlen) text_q.push_back(value_char());
        case ($urandom_range(3))
          0: text_q.push_back(CH_AMP);
          1: text_q.push_back(CH_SEMI);
          2: text_q.push_back(CH_LF);
          default: ;
        endcase
      end else begin
        repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(1, 255)));
      end
    end
    if ($urandom_range(99) < 12) begin
      text_q.push_back(CH_NUL);
      repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input logic [63:0] lo, input logic [63:0] hi,
                           input logic [4:0] len);
    int unsigned goal;
    set_name(lo, hi, len);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(9) == 0) wait_results();
      build_text();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  initial begin
    txt_if.valid       <= 1'b0;
    txt_if.text_byte   <= 8'h00;
    txt_if.end_of_text <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_NAME_LOW;
    cfg_if.data        <= '0;
    rst_ni             <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset name is a single NUL character: nothing can match
    send_str("?x=5", 1'b1);
    send_byte(8'hFF, 1'b1);

    set_name(64'h6B, 64'h0, 5'd1);
    send_str("?k=&k=", 1'b1);
    send_str("?k=ab", 1'b1);
    send_byte(CH_NUL, 1'b1);
    send_str("&k=z", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_str("xy", 1'b1);

    run_phase(0, 0, rand_word(), rand_word(), 5'd16);
    run_phase(47, 0, 64'h0, '1, 5'd0);
    run_phase(0, 47, '1, rand_word(), 5'd31);
    run_phase(16, 16, rand_word(), 64'h0, 5'($urandom_range(1, 5)));
    run_phase(0, 0, rand_word(), rand_word(), 5'd1);

    wait_results();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* query_token_value_extractor.f */
rtl/qtve_pkg.sv
rtl/qtve_intf.sv
rtl/qtve_win_cell.sv
rtl/qtve_val_cell.sv
rtl/query_token_value_extractor.sv
rtl/qtve_checker.sv
sim/qtve_tb_pkg.sv
sim/query_token_value_extractor_tb.sv
